@@ hw/rtl/fbfl_pkg.sv @@
// Shared constants and types for the fixed-size block allocator.
package fbfl_pkg;

   localparam int NUM_BLOCKS_DEFAULT = 1024;

   localparam int ID_W  = 10;
   localparam int CNT_W_PORT = 11;
   localparam int CAP_W = 11;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

   // Register index of block_capacity within the register map.
   localparam logic REG_BLOCK_CAPACITY = 1'b0;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_OOM    = 2'd1,
      ST_RANGE  = 2'd2,
      ST_DOUBLE = 2'd3
   } status_type;

endpackage

@@ hw/rtl/fbfl_ram.sv @@
// Single-port-write, single-port-read block descriptor memory with registered read data.
module fbfl_ram #(
   parameter int DEPTH = fbfl_pkg::NUM_BLOCKS_DEFAULT,
   parameter int WIDTH = 12,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   import fbfl_pkg::*;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/fixed_block_free_list_allocator.sv @@
// Fixed-size block allocator with a LIFO free list: top level.
// A request is taken into the pending register, and its descriptor read is issued as it is
// accepted; the response is registered once the response register is free or being emptied.
// A new request is not accepted while one is pending, so the descriptor read and write-back
// of one request finish before the next is taken; a response held back by the receiver stalls
// acceptance once one further request is pending.
// Reset is synchronous and active high; counts, free-list head and capacity are restored,
// while the descriptor memory is left as it is and its contents are never used before being written.
module fixed_block_free_list_allocator #(
   parameter int NUM_BLOCKS = fbfl_pkg::NUM_BLOCKS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_op,
   input  logic [fbfl_pkg::ID_W-1:0]        req_free_id,

   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_status,
   output logic [fbfl_pkg::ID_W-1:0]        rsp_result_id,
   output logic [fbfl_pkg::CNT_W_PORT-1:0]  rsp_in_use_count,
   output logic [fbfl_pkg::CNT_W_PORT-1:0]  rsp_high_water_count,

   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [fbfl_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [fbfl_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [fbfl_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);
   import fbfl_pkg::*;

   // Block indexes and counts are sized from the number of blocks the memory holds.
   localparam int IDX_W = $clog2(NUM_BLOCKS);
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
   // Descriptor layout: used mark, link valid, next link.
   localparam int ENT_W = IDX_W + 2;

   // ------------------------------------------------------------------
   // Configuration registers. Only block_capacity exists; it is selected
   // when the top address bit is zero and is written on the access phase of a write.
   // ------------------------------------------------------------------
   logic [CAP_W-1:0] cap_ff, cap_in;
   logic             csr_sel_cap;

   assign pready      = 1'b1;
   assign csr_sel_cap = (paddr[CSR_ADDR_W-1] == REG_BLOCK_CAPACITY);

   always_comb begin
      cap_in = cap_ff;
      if (psel && penable && pwrite && pready && csr_sel_cap) begin
         cap_in = pwdata[CAP_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (csr_sel_cap) begin
         prdata = CSR_DATA_W'(cap_ff);
      end
   end

   // ------------------------------------------------------------------
   // Request capture. The descriptor read is issued in the same cycle as
   // the request transaction: an allocate reads the current free-list
   // head, a free reads the block it names. The request then waits in
   // the pending register until the response register can take it.
   // ------------------------------------------------------------------
   logic              pend_ff, pend_in;
   op_type            op_ff;
   logic [ID_W-1:0]   fid_ff;
   logic              req_fire;
   logic              exec;

   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [ENT_W-1:0]  ram_wr_data;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [ENT_W-1:0]  ram_rd_data;

   // Allocator state.
   logic [IDX_W-1:0]  head_ff, head_in;
   logic              head_valid_ff, head_valid_in;
   logic [CNT_W-1:0]  fresh_ff, fresh_in;
   logic [CNT_W-1:0]  used_cnt_ff, used_cnt_in;

   // Response register.
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic [CNT_W-1:0]  rsp_used_ff, rsp_fresh_ff;

   assign req_ready   = !pend_ff;
   assign req_fire    = req_valid && req_ready;
   // The pending request completes once the response register is free or being emptied.
   assign exec        = pend_ff && (!rsp_valid_ff || rsp_ready);
   assign ram_rd_addr = (op_type'(req_op) == OP_FREE) ? IDX_W'(req_free_id) : head_ff;

   fbfl_ram #(
      .DEPTH (NUM_BLOCKS),
      .WIDTH (ENT_W),
      .AW    (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_fire),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------
   // Completion logic: one pass from the descriptor just read to the
   // write-back, the new head and counts, and the response.
   // ------------------------------------------------------------------
   logic              ent_used;
   logic              ent_link_valid;
   logic [IDX_W-1:0]  ent_next;
   logic              fresh_full;
   logic              fid_bad;

   assign ent_used       = ram_rd_data[ENT_W-1];
   assign ent_link_valid = ram_rd_data[ENT_W-2];
   assign ent_next       = ram_rd_data[IDX_W-1:0];

   // Fresh space runs out at the programmed capacity, clipped to the memory depth.
   assign fresh_full = (32'(fresh_ff) >= 32'(cap_ff)) || (32'(fresh_ff) >= NUM_BLOCKS);
   // Only blocks that were once handed out can be freed.
   assign fid_bad    = (32'(fid_ff) >= 32'(fresh_ff)) || (32'(fid_ff) >= NUM_BLOCKS);

   always_comb begin
      pend_in       = pend_ff;
      head_in       = head_ff;
      head_valid_in = head_valid_ff;
      fresh_in      = fresh_ff;
      used_cnt_in   = used_cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = head_ff;
      ram_wr_data   = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (exec) begin
         pend_in       = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_OK;
         case (op_ff)
            OP_ALLOC: begin
               if (head_valid_ff) begin
                  // Pop the free-list head; the last entry leaves the list empty.
                  rsp_id_in   = ID_W'(head_ff);
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = head_ff;
                  ram_wr_data = {1'b1, 1'b0, {IDX_W{1'b0}}};
                  if (ent_link_valid) begin
                     head_in       = ent_next;
                     head_valid_in = 1'b1;
                  end else begin
                     head_in       = '0;
                     head_valid_in = 1'b0;
                  end
                  used_cnt_in = used_cnt_ff + CNT_W'(1);
               end else if (fresh_full) begin
                  rsp_status_in = ST_OOM;
                  rsp_id_in     = '0;
               end else begin
                  // Hand out the next block from fresh space.
                  rsp_id_in   = ID_W'(fresh_ff);
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = IDX_W'(fresh_ff);
                  ram_wr_data = {1'b1, 1'b0, {IDX_W{1'b0}}};
                  fresh_in    = fresh_ff + CNT_W'(1);
                  used_cnt_in = used_cnt_ff + CNT_W'(1);
               end
            end
            OP_FREE: begin
               rsp_id_in = fid_ff;
               if (fid_bad) begin
                  rsp_status_in = ST_RANGE;
               end else if (!ent_used) begin
                  rsp_status_in = ST_DOUBLE;
               end else begin
                  // Push the block; it links to the old head if there was one.
                  ram_wr_en     = 1'b1;
                  ram_wr_addr   = IDX_W'(fid_ff);
                  ram_wr_data   = {1'b0, head_valid_ff, head_ff};
                  head_in       = IDX_W'(fid_ff);
                  head_valid_in = 1'b1;
                  if (used_cnt_ff != '0) begin
                     used_cnt_in = used_cnt_ff - CNT_W'(1);
                  end
               end
            end
            default: begin
               rsp_status_in = ST_OK;
            end
         endcase
      end

      if (req_fire) begin
         pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff        <= CAP_RESET;
         pend_ff       <= 1'b0;
         head_ff       <= '0;
         head_valid_ff <= 1'b0;
         fresh_ff      <= '0;
         used_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cap_ff        <= cap_in;
         pend_ff       <= pend_in;
         head_ff       <= head_in;
         head_valid_ff <= head_valid_in;
         fresh_ff      <= fresh_in;
         used_cnt_ff   <= used_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff  <= op_type'(req_op);
         fid_ff <= req_free_id;
      end
      if (exec) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_used_ff   <= used_cnt_in;
         rsp_fresh_ff  <= fresh_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_result_id        = rsp_id_ff;
   assign rsp_in_use_count     = CNT_W_PORT'(rsp_used_ff);
   assign rsp_high_water_count = CNT_W_PORT'(rsp_fresh_ff);

endmodule
